>>> design/srrip_pkg.sv
package srrip_pkg;

  localparam int TAG_W        = 64;
  localparam int RRPV_W       = 4;
  localparam int WIDTH_REG_W  = 3;
  localparam int INS_REG_W    = 4;
  localparam int DEFAULT_WAYS = 16;

  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam int OUT_WAY_W    = 4;
  localparam int OUT_OCC_W    = 5;
  localparam int OUT_TDATA_W  = 16;

  typedef enum logic [0:0] {
    REG_RRPV_WIDTH  = 1'b0,
    REG_INSERT_RRPV = 1'b1
  } reg_idx_t;

  localparam logic [WIDTH_REG_W-1:0] RRPV_WIDTH_RST  = 3'd2;
  localparam logic [INS_REG_W-1:0]   INSERT_RRPV_RST = 4'd2;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0] rrpv_width;
    logic [INS_REG_W-1:0]   insert_rrpv;
  } cfg_t;

  // Largest prediction value for a width; widths below 1 act as 1, above 4 as 4.
  function automatic logic [RRPV_W-1:0] rrpv_ceiling(input logic [WIDTH_REG_W-1:0] w);
    logic [RRPV_W-1:0] mx;
    case (w) inside
      3'd0, 3'd1: mx = 4'd1;
      3'd2:       mx = 4'd3;
      3'd3:       mx = 4'd7;
      default:    mx = 4'd15;
    endcase
    return mx;
  endfunction

endpackage

>>> design/srrip_cfg_regs.sv
module srrip_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [srrip_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [srrip_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [srrip_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready,
  output srrip_pkg::cfg_t                    cfg
);

  srrip_pkg::reg_idx_t idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = srrip_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rrpv_width  <= srrip_pkg::RRPV_WIDTH_RST;
      cfg.insert_rrpv <= srrip_pkg::INSERT_RRPV_RST;
    end else if (wr_en) begin
      case (idx)
        srrip_pkg::REG_RRPV_WIDTH:
          cfg.rrpv_width <= pwdata[srrip_pkg::WIDTH_REG_W-1:0];
        srrip_pkg::REG_INSERT_RRPV:
          cfg.insert_rrpv <= pwdata[srrip_pkg::INS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      srrip_pkg::REG_RRPV_WIDTH:
        prdata = {{(srrip_pkg::APB_DATA_W-srrip_pkg::WIDTH_REG_W){1'b0}}, cfg.rrpv_width};
      srrip_pkg::REG_INSERT_RRPV:
        prdata = {{(srrip_pkg::APB_DATA_W-srrip_pkg::INS_REG_W){1'b0}}, cfg.insert_rrpv};
      default:
        prdata = '0;
    endcase
  end

endmodule

>>> design/srrip_way_store.sv
module srrip_way_store #(
  parameter int WAYS  = srrip_pkg::DEFAULT_WAYS,
  parameter int WAY_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          upd,
  input  logic [srrip_pkg::TAG_W-1:0]   tag,
  input  srrip_pkg::cfg_t               cfg,
  output logic                          hit,
  output logic [WAY_W-1:0]              way,
  output logic [CNT_W-1:0]              fill_after
);

  localparam int RW = srrip_pkg::RRPV_W;
  localparam int NV = 2 ** RW;

  logic [srrip_pkg::TAG_W-1:0] tags [WAYS];
  logic [RW-1:0]               rrpv [WAYS];
  logic [CNT_W-1:0]            fill_count;

  logic [RW-1:0]    mx;
  logic [RW-1:0]    ins;
  logic             full;
  logic [WAY_W-1:0] hit_way;
  logic [RW-1:0]    sat [WAYS];
  logic [NV-1:0]    present;
  logic [RW-1:0]    largest;
  logic [RW-1:0]    delta;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] fill_way;

  assign mx       = srrip_pkg::rrpv_ceiling(cfg.rrpv_width);
  assign ins      = (cfg.insert_rrpv > mx) ? mx : cfg.insert_rrpv;
  assign full     = (fill_count == CNT_W'(WAYS));
  assign fill_way = fill_count[WAY_W-1:0];

  // Lowest valid way whose tag matches
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < fill_count) && (tags[i] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
    end
  end

  // Values above the maximum count as the maximum
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      sat[i] = (rrpv[i] > mx) ? mx : rrpv[i];
    end
  end

  // Which values occur, then the largest one
  always_comb begin
    present = '0;
    for (int v = 0; v < NV; v++) begin
      for (int i = 0; i < WAYS; i++) begin
        if (sat[i] == RW'(v)) present[v] = 1'b1;
      end
    end
    largest = '0;
    for (int v = 0; v < NV; v++) begin
      if (present[v]) largest = RW'(v);
    end
  end

  // Aging by the gap lets the lowest way holding the largest value reach the maximum
  always_comb begin
    victim = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (sat[i] == largest) victim = WAY_W'(i);
    end
  end

  assign delta = mx - largest;

  always_comb begin
    if (hit)       way = hit_way;
    else if (!full) way = fill_way;
    else           way = victim;
  end

  assign fill_after = (!hit && !full) ? fill_count + CNT_W'(1) : fill_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (upd) begin
      fill_count <= fill_after;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      if (hit) begin
        rrpv[hit_way] <= '0;
      end else if (!full) begin
        tags[fill_way] <= tag;
        rrpv[fill_way] <= ins;
      end else begin
        for (int i = 0; i < WAYS; i++) begin
          rrpv[i] <= (WAY_W'(i) == victim) ? ins : rrpv[i] + delta;
        end
        tags[victim] <= tag;
      end
    end
  end

endmodule

>>> design/srrip_fully_assoc_lookup.sv
// Fully associative tag lookup with static re-reference interval replacement.
//
// Input stream (s_*): one 64-bit tag per item in s_tdata.
// Output stream (m_*): one result per tag, in order. m_tuser carries the
// hit flag; m_tdata holds the way that now holds the tag and the number of
// valid ways after the access.
// Configuration: APB port with the prediction width at 0x0 and the insert
// value at 0x4; write only while no tag is in flight.
//
// A tag accepted into the input register has its result written to the result
// register and shown on m_tvalid. Throughput is one tag per cycle while the
// result is not stalled: the whole compare, aging and victim choice over all
// ways is one combinational pass between the input and result registers, and
// the store updates at the same edge that the result is registered, so the
// following tag sees the new state. When m_tready is low the result holds, the
// input register holds a second tag, and s_tready drops until the result is taken.
// Reset clears the valid count (the store is empty), the input and result valid
// flags and the registers back to width 2, insert value 2. No clearing pass.
module srrip_fully_assoc_lookup #(
  parameter int WAYS = srrip_pkg::DEFAULT_WAYS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [srrip_pkg::TAG_W-1:0]          s_tdata,  // [63:0] tag
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [srrip_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [3:0] way_index, [8:4] occupancy
  output logic                                 m_tuser,  // [0] hit
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [srrip_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [srrip_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [srrip_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int OW    = srrip_pkg::OUT_WAY_W;
  localparam int OC    = srrip_pkg::OUT_OCC_W;

  srrip_pkg::cfg_t cfg;

  logic                        in_valid;
  logic [srrip_pkg::TAG_W-1:0] in_tag;
  logic                        advance;
  logic                        lk_hit;
  logic [WAY_W-1:0]            lk_way;
  logic [CNT_W-1:0]            lk_fill;
  logic [WAY_W+OW-1:0]         way_ext;
  logic [CNT_W+OC-1:0]         occ_ext;
  logic [OW-1:0]               res_way;
  logic [OC-1:0]               res_occ;
  logic                        res_hit;

  srrip_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Result register can load when empty or being drained
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_tag <= s_tdata;
  end

  srrip_way_store #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W),
    .CNT_W (CNT_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .upd        (in_valid && advance),
    .tag        (in_tag),
    .cfg        (cfg),
    .hit        (lk_hit),
    .way        (lk_way),
    .fill_after (lk_fill)
  );

  assign way_ext = {{OW{1'b0}}, lk_way};
  assign occ_ext = {{OC{1'b0}}, lk_fill};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res_hit <= lk_hit;
      res_way <= way_ext[OW-1:0];
      res_occ <= occ_ext[OC-1:0];
    end
  end

  assign m_tuser = res_hit;
  assign m_tdata = {{(srrip_pkg::OUT_TDATA_W-OW-OC){1'b0}}, res_occ, res_way};

endmodule

>>> design/srrip_checker.sv
module srrip_checker #(
  parameter int WAYS = srrip_pkg::DEFAULT_WAYS
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [srrip_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                              m_tuser,
  input logic                              pready
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Input side only backs up when a result is waiting and the output is stalled
  a_back_pressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output stall");

  // A hit leaves at least one valid way
  a_hit_occ: assert property (@(posedge clk) disable iff (rst)
    (WAYS < 32) && m_tvalid && m_tuser |-> m_tdata[8:4] != 5'd0)
    else $error("hit with empty store");

  // The way reported always lies below the valid count
  a_way_range: assert property (@(posedge clk) disable iff (rst)
    (WAYS <= 16) && m_tvalid |-> m_tdata[3:0] < m_tdata[8:4])
    else $error("way index beyond occupancy");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> pready)
    else $error("configuration port not ready");

endmodule

bind srrip_fully_assoc_lookup srrip_checker #(.WAYS(WAYS)) u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .pready   (pready)
);

>>> dv/srrip_fully_assoc_lookup_test.sv
module srrip_fully_assoc_lookup_test;

  localparam int WAYS        = srrip_pkg::DEFAULT_WAYS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic                            hit;
    logic [srrip_pkg::OUT_WAY_W-1:0] way;
    logic [srrip_pkg::OUT_OCC_W-1:0] occ;
  } lookup_res_t;

  typedef struct packed {
    bit                          is_cfg;
    srrip_pkg::reg_idx_t         cfg_reg;
    logic [31:0]                 cfg_val;
    logic [srrip_pkg::TAG_W-1:0] tag;
    bit                          typed;
    lookup_res_t                 res;
  } stim_row_t;

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [srrip_pkg::TAG_W-1:0]       s_tdata;   // [63:0] tag
  logic                              m_tvalid;
  logic                              m_tready;
  logic [srrip_pkg::OUT_TDATA_W-1:0] m_tdata;   // [3:0] way_index, [8:4] occupancy
  logic                              m_tuser;   // [0] hit
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [srrip_pkg::APB_ADDR_W-1:0]  paddr;
  logic [srrip_pkg::APB_DATA_W-1:0]  pwdata;
  logic [srrip_pkg::APB_DATA_W-1:0]  prdata;
  logic                              pready;

  // Shadow copy of the tag store and its prediction values
  logic [srrip_pkg::TAG_W-1:0]       tag_mem [WAYS];
  logic [srrip_pkg::RRPV_W-1:0]      rrpv_mem [WAYS];
  int                                fill_cnt;
  logic [srrip_pkg::WIDTH_REG_W-1:0] cfg_width;
  logic [srrip_pkg::INS_REG_W-1:0]   cfg_insert;

  lookup_res_t                       pending_results[$];
  stim_row_t                         dir_rows[$];
  logic [srrip_pkg::TAG_W-1:0]       tag_pool[$];
  int                                errors;
  int                                cycles;
  bit                                src_steady;
  bit                                sink_steady;
  bit                                hold_req;
  int                                hold_left;

  srrip_fully_assoc_lookup #(.WAYS(WAYS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic lookup_res_t lookup_res(input bit h, input int w, input int o);
    lookup_res_t r;
    r.hit = h;
    r.way = w[srrip_pkg::OUT_WAY_W-1:0];
    r.occ = o[srrip_pkg::OUT_OCC_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t tag_row(input logic [srrip_pkg::TAG_W-1:0] t, input bit typed,
                                        input lookup_res_t r);
    stim_row_t row;
    row = '0;
    row.tag = t;
    row.typed = typed;
    row.res = r;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input srrip_pkg::reg_idx_t idx, input logic [31:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_reg = idx;
    row.cfg_val = v;
    return row;
  endfunction

  // Hit clears the way; a miss fills the next free way or, once the store is
  // full, replaces the lowest way at the ceiling, first aging all ways if none is.
  task automatic predict_lookup(input logic [srrip_pkg::TAG_W-1:0] t, output lookup_res_t r);
    int                           wd;
    int                           way;
    bit                           found;
    bit                           picked;
    logic [srrip_pkg::RRPV_W-1:0] ceil_val;
    logic [srrip_pkg::RRPV_W-1:0] ins;
    logic [srrip_pkg::RRPV_W-1:0] largest;
    logic [srrip_pkg::RRPV_W-1:0] delta;
    wd = cfg_width;
    if (wd < 1) wd = 1;
    if (wd > 4) wd = 4;
    ceil_val = srrip_pkg::RRPV_W'((1 << wd) - 1);
    ins = (cfg_insert > ceil_val) ? ceil_val : cfg_insert;
    found = 1'b0;
    way = 0;
    for (int i = 0; i < fill_cnt; i++) begin
      if (!found && tag_mem[i] == t) begin
        found = 1'b1;
        way = i;
      end
    end
    if (found) begin
      rrpv_mem[way] = '0;
    end else begin
      if (fill_cnt < WAYS) begin
        way = fill_cnt;
        fill_cnt++;
      end else begin
        picked = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
          if (!picked && rrpv_mem[i] >= ceil_val) begin
            picked = 1'b1;
            way = i;
          end
        end
        if (!picked) begin
          largest = '0;
          for (int i = 0; i < WAYS; i++)
            if (rrpv_mem[i] > largest) largest = rrpv_mem[i];
          delta = ceil_val - largest;
          for (int i = 0; i < WAYS; i++) begin
            if (!picked && rrpv_mem[i] == largest) begin
              picked = 1'b1;
              way = i;
            end
          end
          for (int i = 0; i < WAYS; i++) rrpv_mem[i] = rrpv_mem[i] + delta;
        end
      end
      tag_mem[way] = t;
      rrpv_mem[way] = ins;
    end
    r = lookup_res(found, way, fill_cnt);
  endtask

  task automatic send_tag(input logic [srrip_pkg::TAG_W-1:0] t, input bit typed,
                          input lookup_res_t typed_res);
    lookup_res_t r;
    while (!src_steady && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= t;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_lookup(t, r);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
  endtask

  // Drain every result before touching the registers
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input srrip_pkg::reg_idx_t idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == srrip_pkg::REG_RRPV_WIDTH) cfg_width = v[srrip_pkg::WIDTH_REG_W-1:0];
    else cfg_insert = v[srrip_pkg::INS_REG_W-1:0];
  endtask

  function automatic logic [srrip_pkg::TAG_W-1:0] rand_tag();
    return {$urandom, $urandom};
  endfunction

  // Result checker
  always @(posedge clk) begin
    lookup_res_t want;
    lookup_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = lookup_res(m_tuser, m_tdata[3:0], m_tdata[8:4]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got hit=%0d way=%0d occ=%0d",
                 $time, got.hit, got.way, got.occ);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0d, got %0d", $time, want.hit, got.hit);
          errors++;
        end
        if (got.way !== want.way) begin
          $display("%0t: way_index mismatch, expected %0d, got %0d",
                   $time, want.way, got.way);
          errors++;
        end
        if (got.occ !== want.occ) begin
          $display("%0t: occupancy mismatch, expected %0d, got %0d",
                   $time, want.occ, got.occ);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= sink_steady || ($urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("srrip_fully_assoc_lookup regression: fail");
      $finish;
    end
  end

  initial begin
    int                          widths [PHASES];
    int                          inserts [PHASES];
    int                          pool_n;
    logic [srrip_pkg::TAG_W-1:0] t;
    stim_row_t                   row;
    errors = 0;
    cycles = 0;
    src_steady = 1'b0;
    sink_steady = 1'b0;
    hold_req = 1'b0;
    fill_cnt = 0;
    cfg_width = srrip_pkg::RRPV_WIDTH_RST;
    cfg_insert = srrip_pkg::INSERT_RRPV_RST;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of the tag, hits on two of them, then fill the store
    dir_rows.insert(dir_rows.size(),
                    tag_row(64'h8000_0000_0000_0000, 1, lookup_res(0, 0, 1)));
    dir_rows.insert(dir_rows.size(),
                    tag_row(64'h7FFF_FFFF_FFFF_FFFF, 1, lookup_res(0, 1, 2)));
    dir_rows.insert(dir_rows.size(), tag_row(64'h0, 1, lookup_res(0, 2, 3)));
    dir_rows.insert(dir_rows.size(),
                    tag_row(64'hFFFF_FFFF_FFFF_FFFF, 1, lookup_res(0, 3, 4)));
    dir_rows.insert(dir_rows.size(),
                    tag_row(64'h8000_0000_0000_0000, 1, lookup_res(1, 0, 4)));
    dir_rows.insert(dir_rows.size(),
                    tag_row(64'hFFFF_FFFF_FFFF_FFFF, 1, lookup_res(1, 3, 4)));
    for (int i = 4; i < WAYS; i++)
      dir_rows.insert(dir_rows.size(),
                      tag_row({32'hC0DE_0000, i}, 1, lookup_res(0, i, i + 1)));
    // Full store: aging, lowered width, out-of-range width, saturated insert
    dir_rows.insert(dir_rows.size(), tag_row(64'h1, 0, '0));
    dir_rows.insert(dir_rows.size(), cfg_row(srrip_pkg::REG_RRPV_WIDTH, 1));
    dir_rows.insert(dir_rows.size(), tag_row(64'h2, 0, '0));
    dir_rows.insert(dir_rows.size(), cfg_row(srrip_pkg::REG_RRPV_WIDTH, 0));
    dir_rows.insert(dir_rows.size(), cfg_row(srrip_pkg::REG_INSERT_RRPV, 15));
    dir_rows.insert(dir_rows.size(), tag_row(64'h3, 0, '0));
    dir_rows.insert(dir_rows.size(), cfg_row(srrip_pkg::REG_RRPV_WIDTH, 7));
    dir_rows.insert(dir_rows.size(), tag_row(64'h4, 0, '0));
    dir_rows.insert(dir_rows.size(), cfg_row(srrip_pkg::REG_RRPV_WIDTH, 4));
    dir_rows.insert(dir_rows.size(), cfg_row(srrip_pkg::REG_INSERT_RRPV, 0));
    dir_rows.insert(dir_rows.size(), tag_row(64'h5, 0, '0));
    dir_rows.insert(dir_rows.size(), tag_row(64'h5, 0, '0));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.cfg_reg, row.cfg_val);
      end else begin
        send_tag(row.tag, row.typed, row.res);
      end
    end

    widths  = '{2, 1, 4, 3, 0, 5, 7, 4};
    inserts = '{2, 0, 15, 5, 9, 1, 7, 3};
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(srrip_pkg::REG_RRPV_WIDTH, widths[p]);
      write_reg(srrip_pkg::REG_INSERT_RRPV, inserts[p]);
      // A pool a bit larger than the store keeps hits and evictions both common
      tag_pool.delete();
      pool_n = 18 + 4 * (p % 3);
      for (int k = 0; k < pool_n; k++) tag_pool.insert(tag_pool.size(), rand_tag());
      tag_pool.insert(tag_pool.size(), 64'h8000_0000_0000_0000);
      tag_pool.insert(tag_pool.size(), 64'h7FFF_FFFF_FFFF_FFFF);
      src_steady = (p == 2);
      sink_steady = (p == 2);
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) begin
          s_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        if ($urandom_range(99) < 85) t = tag_pool[$urandom_range(tag_pool.size() - 1)];
        else t = rand_tag();
        send_tag(t, 0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("srrip_fully_assoc_lookup regression: pass");
    end else begin
      $display("srrip_fully_assoc_lookup regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
design/srrip_pkg.sv
design/srrip_cfg_regs.sv
design/srrip_way_store.sv
design/srrip_fully_assoc_lookup.sv
design/srrip_checker.sv
dv/srrip_fully_assoc_lookup_test.sv
